### hw/rtl/mt19937_random_word_source_core_macros.svh
// Assertion macros used by the random word source core.
`ifndef MT19937_RANDOM_WORD_SOURCE_CORE_MACROS_SVH
`define MT19937_RANDOM_WORD_SOURCE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MTRWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTRWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mtrws_pkg.sv
// Shared types and constants of the MT19937 random word source.
package mtrws_pkg;

    localparam int unsigned TABLE_WORDS = 624;
    localparam int unsigned TAP_OFFSET  = 397;
    localparam int unsigned ADDR_W      = $clog2(TABLE_WORDS);
    localparam int unsigned COUNT_W     = 48;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [ADDR_W:0]    t_addr_sum;
    typedef logic [31:0]        t_word;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_addr LAST_ADDR = t_addr'(TABLE_WORDS - 1);

    localparam t_word TWIST_XOR     = 32'h9908_b0df;
    localparam t_word TOP_BIT_MASK  = 32'h8000_0000;
    localparam t_word LOW_BITS_MASK = 32'h7fff_ffff;
    localparam t_word TEMPER_B      = 32'h9d2c_5680;
    localparam t_word TEMPER_C      = 32'hefc6_0000;
    localparam t_word INIT_MULT     = 32'd1812433253;
    localparam t_word MIX_MULT_1    = 32'd1664525;
    localparam t_word MIX_MULT_2    = 32'd1566083941;
    localparam t_word INIT_SEED     = 32'd19650218;

    localparam t_count COUNT_MAX = '1;

    // One table access per cycle: a write and the first read port.
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr;
    } t_mem_req;

endpackage

### hw/rtl/mtrws_req_if.sv
// Request channel: valid/ready handshake with the draw request payload.
interface mtrws_req_if ();
    logic        valid;
    logic        ready;
    logic        mode;
    logic [5:0]  req_bits;
    logic [31:0] req_bound;

    modport source (output valid, output mode, output req_bits, output req_bound,
                    input ready);
    modport sink   (input valid, input mode, input req_bits, input req_bound,
                    output ready);
endinterface

### hw/rtl/mtrws_rsp_if.sv
// Response channel: valid/ready handshake with the random result payload.
interface mtrws_rsp_if ();
    logic        valid;
    logic        ready;
    logic [31:0] random_value;
    logic [47:0] words_used;

    modport source (output valid, output random_value, output words_used, input ready);
    modport sink   (input valid, input random_value, input words_used, output ready);
endinterface

### hw/rtl/mtrws_ram.sv
// Twister table: one write port, two registered read ports.
module mtrws_ram (
    input  logic               i_clk,
    input  mtrws_pkg::t_mem_req i_req,
    input  mtrws_pkg::t_addr   i_raddr_b,
    output mtrws_pkg::t_word   o_rdata_a,
    output mtrws_pkg::t_word   o_rdata_b
);
    import mtrws_pkg::*;

    t_word r_mem [TABLE_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata_a <= r_mem[i_req.raddr];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hw/rtl/mtrws_seeder.sv
// Seeding sequencer: linear fill, two key-mixing passes, final word 0 write.
module mtrws_seeder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mtrws_pkg::t_word    i_key,
    input  mtrws_pkg::t_word    i_rdata,
    output mtrws_pkg::t_mem_req o_req,
    output logic                o_busy,
    output logic                o_done
);
    import mtrws_pkg::*;

    typedef enum logic [2:0] {
        SD_IDLE,
        SD_FILL_M,
        SD_FILL_W,
        SD_MIX_M,
        SD_MIX_W,
        SD_LAST
    } t_sd_state;

    t_sd_state r_state;
    t_addr     r_pos;
    t_addr     r_n;
    logic      r_pass2;
    t_word     r_p;      // last word written (INIT_SEED at the start of each phase), the "previous" entry of every step
    t_word     r_prod;

    t_word w_x;
    t_word w_mult;
    t_word w_prod;
    t_word w_fill;
    t_word w_mixed;
    t_word w_mix;
    t_addr w_pos_next;
    logic  w_n_last;

    always_comb begin
        w_x    = r_p ^ (r_p >> 30);
        if (r_state == SD_FILL_M) begin
            w_mult = INIT_MULT;
        end else if (r_pass2) begin
            w_mult = MIX_MULT_2;
        end else begin
            w_mult = MIX_MULT_1;
        end
        w_prod  = w_x * w_mult;
        w_fill  = r_prod + t_word'(r_pos);
        w_mixed = i_rdata ^ r_prod;
        w_mix   = r_pass2 ? (w_mixed - t_word'(r_pos)) : (w_mixed + i_key);
        // word 0 is never read back during mixing, so the wrap copy is dropped
        w_pos_next = (r_pos == LAST_ADDR) ? t_addr'(1) : (r_pos + t_addr'(1));
        w_n_last   = r_pass2 ? (r_n == t_addr'(TABLE_WORDS - 2)) : (r_n == LAST_ADDR);
    end

    always_comb begin
        o_req.we    = (r_state == SD_FILL_W) || (r_state == SD_MIX_W) || (r_state == SD_LAST);
        o_req.waddr = (r_state == SD_LAST) ? '0 : r_pos;
        o_req.raddr = r_pos;
        case (r_state)
            SD_FILL_W: o_req.wdata = w_fill;
            SD_MIX_W:  o_req.wdata = w_mix;
            default:   o_req.wdata = TOP_BIT_MASK;
        endcase
    end

    assign o_busy = (r_state != SD_IDLE);
    assign o_done = (r_state == SD_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_state <= SD_FILL_M;
            r_pos   <= t_addr'(1);
            r_n     <= '0;
            r_pass2 <= 1'b0;
            r_p     <= INIT_SEED;
        end else begin
            case (r_state)
                SD_FILL_M: begin
                    r_prod  <= w_prod;
                    r_state <= SD_FILL_W;
                end
                SD_FILL_W: begin
                    if (r_pos == LAST_ADDR) begin
                        r_p     <= INIT_SEED;
                        r_pos   <= t_addr'(1);
                        r_n     <= '0;
                        r_state <= SD_MIX_M;
                    end else begin
                        r_p     <= w_fill;
                        r_pos   <= r_pos + t_addr'(1);
                        r_state <= SD_FILL_M;
                    end
                end
                SD_MIX_M: begin
                    r_prod  <= w_prod;
                    r_state <= SD_MIX_W;
                end
                SD_MIX_W: begin
                    r_p   <= w_mix;
                    r_pos <= w_pos_next;
                    if (w_n_last) begin
                        r_n <= '0;
                        if (r_pass2) begin
                            r_state <= SD_LAST;
                        end else begin
                            r_pass2 <= 1'b1;
                            r_state <= SD_MIX_M;
                        end
                    end else begin
                        r_n     <= r_n + t_addr'(1);
                        r_state <= SD_MIX_M;
                    end
                end
                SD_LAST: begin
                    r_state <= SD_IDLE;
                end
                SD_IDLE: begin
                    r_state <= SD_IDLE;
                end
                default: begin
                    r_state <= SD_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/mt19937_random_word_source_core.sv
// MT19937 random word source: top-bits and bounded draws from a 624-word table.
//
// Requests arrive on i_req (mode, req_bits, req_bound) and each gives exactly one
// response on o_rsp (random_value, words_used); both are valid/ready channels and a
// transfer happens on a clock edge with valid and ready high.
// A request that draws one word goes through the table read/twist/write-back,
// temper/check and output load steps before its response is registered. Each
// rejected draw in bound mode repeats the twist and check steps. A request that
// draws no word (bad bit count, zero bound) goes straight to the output load. The
// next request is taken only once the response is loaded and the block is idle
// again. The table is twisted one word per draw, so regeneration is spread over the
// draws and costs nothing extra.
// The response sits in an output register; while it waits the block accepts and
// works the next request, and stalls that one only when its own result is ready.
// Reset (synchronous, active low) or a write on i_cfg_we reseeds the table: the
// seeding sequencer fills and mixes the table one word at a time through the shared
// multiplier and read port, with i_req.ready low throughout. The word count
// restarts at zero.
`include "mt19937_random_word_source_core_macros.svh"

module mt19937_random_word_source_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  mtrws_pkg::t_word  i_cfg_wdata,
    mtrws_req_if.sink         i_req,
    mtrws_rsp_if.source       o_rsp
);
    import mtrws_pkg::*;

    typedef enum logic [2:0] {
        S_SEED,
        S_IDLE,
        S_TW,
        S_CHK,
        S_DONE
    } t_state;

    t_state     r_state;
    t_word      r_seed;
    t_addr      r_k;       // next table word to twist and draw
    t_word      r_cur;     // untwisted copy of word r_k
    t_word      r_word;
    t_count     r_count;
    logic       r_mode;
    logic [4:0] r_shamt;
    t_word      r_bound;
    t_word      r_res;
    logic       r_out_valid;
    t_word      r_out_value;
    t_count     r_out_used;

    t_mem_req   w_seed_req;
    t_mem_req   w_mem_req;
    logic       w_seed_busy;
    logic       w_seed_done;
    t_word      w_rd_a;
    t_word      w_rd_b;
    t_addr      w_addr_a;
    t_addr_sum  w_tap_sum;
    t_addr      w_addr_b;
    t_word      w_y;
    t_word      w_twisted;
    t_word      w_tempered;
    t_word      w_value;
    logic       w_take;
    logic       w_in_xfer;
    logic       w_out_free;
    logic       w_out_load;
    logic [5:0] w_bc_diff;
    logic       w_draw;
    logic [4:0] w_shamt;

    function automatic logic [4:0] msb_index(input t_word x);
        t_word      v;
        logic [4:0] p;
        v = x;
        p = '0;
        if (v[31:16] != '0) begin
            p[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[15:8] != '0) begin
            p[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[7:4] != '0) begin
            p[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[3:2] != '0) begin
            p[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[1]) begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

    function automatic t_word temper(input t_word x);
        t_word v;
        v = x ^ (x >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

    mtrws_seeder u_seeder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_key   (r_seed),
        .i_rdata (w_rd_a),
        .o_req   (w_seed_req),
        .o_busy  (w_seed_busy),
        .o_done  (w_seed_done)
    );

    mtrws_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_comb begin
        w_addr_a  = (r_k == LAST_ADDR) ? '0 : (r_k + t_addr'(1));
        w_tap_sum = {1'b0, r_k} + t_addr_sum'(TAP_OFFSET);
        if (w_tap_sum >= t_addr_sum'(TABLE_WORDS)) begin
            w_addr_b = t_addr'(w_tap_sum - t_addr_sum'(TABLE_WORDS));
        end else begin
            w_addr_b = t_addr'(w_tap_sum);
        end

        // word k+1 is still old but for word 0 at the wrap, word k+397 already new once it has wrapped
        w_y       = (r_cur & TOP_BIT_MASK) | (w_rd_a & LOW_BITS_MASK);
        w_twisted = w_rd_b ^ (w_y >> 1) ^ (w_y[0] ? TWIST_XOR : '0);

        if (w_seed_busy) begin
            w_mem_req = w_seed_req;
        end else begin
            w_mem_req.we    = (r_state == S_TW);
            w_mem_req.waddr = r_k;
            w_mem_req.wdata = w_twisted;
            w_mem_req.raddr = w_addr_a;
        end

        w_tempered = temper(r_word);
        w_value    = w_tempered >> r_shamt;
        w_take     = !r_mode || (w_value < r_bound);

        w_bc_diff = 6'd32 - i_req.req_bits;
        if (i_req.mode) begin
            w_draw  = (i_req.req_bound != '0);
            w_shamt = ~msb_index(i_req.req_bound);
        end else begin
            w_draw  = (i_req.req_bits != '0) && (i_req.req_bits <= 6'd32);
            w_shamt = w_bc_diff[4:0];
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign w_in_xfer          = i_req.valid && i_req.ready;
    assign w_out_free         = !r_out_valid || o_rsp.ready;
    assign w_out_load         = !i_cfg_we && (r_state == S_DONE) && w_out_free;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out_value;
    assign o_rsp.words_used   = r_out_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SEED;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_seed  <= i_cfg_wdata;
                r_state <= S_SEED;
            end else begin
                case (r_state)
                    S_SEED: begin
                        if (w_seed_done) begin
                            r_k     <= '0;
                            r_cur   <= TOP_BIT_MASK;
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_in_xfer) begin
                            r_mode  <= i_req.mode;
                            r_bound <= i_req.req_bound;
                            r_shamt <= w_shamt;
                            r_res   <= '0;
                            r_state <= w_draw ? S_TW : S_DONE;
                        end
                    end
                    S_TW: begin
                        r_word <= w_twisted;
                        r_cur  <= w_rd_a;
                        r_k    <= w_addr_a;
                        if (r_count != COUNT_MAX) begin
                            r_count <= r_count + t_count'(1);
                        end
                        r_state <= S_CHK;
                    end
                    S_CHK: begin
                        if (w_take) begin
                            r_res   <= w_value;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TW;
                        end
                    end
                    S_DONE: begin
                        if (w_out_free) begin
                            r_out_value <= r_res;
                            r_out_used  <= r_count;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_SEED;
                    end
                endcase
            end
        end
    end

    `MTRWS_ASSERT_NOW(a_seed_owns_table, i_clk, i_rst_n, w_seed_busy, r_state == S_SEED, "draw logic active while seeding")
    `MTRWS_ASSERT_NOW(a_index_in_table, i_clk, i_rst_n, r_state != S_SEED, r_k <= LAST_ADDR, "draw index past table end")
    `MTRWS_ASSERT_NEXT(a_count_no_drop, i_clk, i_rst_n, (r_state != S_SEED) && !i_cfg_we, r_count >= $past(r_count), "word count went down without reseed")

endmodule
